[sv/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bump slot allocator: status codes,
// request kinds, register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int SLOT_COUNT_DEFAULT = 64;
   localparam int DATA_WIDTH         = 32;
   localparam int OWNER_WIDTH        = 16;
   localparam int SLOT_INDEX_WIDTH   = 6;
   localparam int CSR_INDEX_WIDTH    = 2;

   localparam logic [DATA_WIDTH-1:0] ALIGN_MASK = 32'd63;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POOL_SIZE    = 2'd1;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_NO_SLOT  = 2'd2,
      ST_NO_OWNER = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      REQ_ALLOC   = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } dp_status_type;

endpackage

[sv/bsa_ctrl.sv]
// ----------------------------------------------------------------------------
// bsa_ctrl
// Controller state machine: takes a request, runs the slot table scan,
// evaluates pool space and commits the result once the output is free.
// ----------------------------------------------------------------------------
module bsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bsa_pkg::dp_status_type status,
   output bsa_pkg::ctrl_cmd_type  cmd
);

   bsa_pkg::state_type state_ff;
   bsa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bsa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bsa_pkg::S_SCAN;
            end
         end
         bsa_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = bsa_pkg::S_DECIDE;
            end
         end
         bsa_pkg::S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = bsa_pkg::S_COMMIT;
         end
         bsa_pkg::S_COMMIT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = bsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bsa_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[sv/bsa_datapath.sv]
// ----------------------------------------------------------------------------
// bsa_datapath
// Slot table memories, alive and written flags, scan trackers, bump and
// live-byte counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module bsa_datapath #(
   parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bsa_pkg::ctrl_cmd_type                  cmd,
   output bsa_pkg::dp_status_type                 status,
   input  logic                                   req_type,
   input  logic [bsa_pkg::DATA_WIDTH-1:0]         req_request_bytes,
   input  logic [bsa_pkg::OWNER_WIDTH-1:0]        req_owner_layer,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bsa_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bsa_pkg::DATA_WIDTH-1:0]         csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [bsa_pkg::DATA_WIDTH-1:0]         rsp_address,
   output logic [bsa_pkg::SLOT_INDEX_WIDTH-1:0]   rsp_slot_index,
   output logic [bsa_pkg::DATA_WIDTH-1:0]         rsp_live_bytes
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = IDX_W + 1;
   localparam int DW    = bsa_pkg::DATA_WIDTH;
   localparam int OW    = bsa_pkg::OWNER_WIDTH;

   // slot table
   logic [DW-1:0] offset_mem [SLOT_COUNT];
   logic [DW-1:0] size_mem   [SLOT_COUNT];
   logic [OW-1:0] owner_mem  [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] alive_ff, alive_in;
   logic [SLOT_COUNT-1:0] written_ff, written_in;

   // configuration
   logic [DW-1:0] base_ff, base_in;
   logic [DW-1:0] pool_ff, pool_in;

   // request
   bsa_pkg::req_kind_type req_kind_ff, req_kind_in;
   logic [DW-1:0]         bytes_ff, bytes_in;
   logic [OW-1:0]         owner_ff, owner_in;
   logic [DW:0]           rounded_ff, rounded_in;

   // scan
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic             issue;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [DW-1:0]    rd_offset_ff, rd_size_ff;
   logic [OW-1:0]    rd_owner_ff;
   logic             rd_alive_ff, rd_written_ff;
   logic [DW-1:0]    ent_offset, ent_size;

   logic             rel_found_ff, rel_found_in;
   logic [IDX_W-1:0] rel_idx_ff, rel_idx_in;
   logic [DW-1:0]    rel_size_ff, rel_size_in;
   logic             reu_found_ff, reu_found_in;
   logic [IDX_W-1:0] reu_idx_ff, reu_idx_in;
   logic [DW-1:0]    reu_size_ff, reu_size_in;
   logic [DW-1:0]    reu_offset_ff, reu_offset_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // space check
   logic [DW+1:0] space_sum;
   logic          space_fail_ff, space_fail_in;
   logic [DW-1:0] new_bump_ff, new_bump_in;

   // counters and write port
   logic [DW-1:0]    bump_ff, bump_in;
   logic [DW-1:0]    live_ff, live_in;
   logic             geom_we, owner_we;
   logic [IDX_W-1:0] wr_idx;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   bsa_pkg::status_type                  rsp_status_ff, rsp_status_in;
   logic [DW-1:0]                        rsp_address_ff, rsp_address_in;
   logic [bsa_pkg::SLOT_INDEX_WIDTH-1:0] rsp_slot_index_ff, rsp_slot_index_in;
   logic [DW-1:0]                        rsp_live_ff, rsp_live_in;

   assign csr_ready = 1'b1;

   assign status.scan_done = (issue_cnt_ff == CNT_W'(SLOT_COUNT)) && !rd_valid_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_live_bytes = rsp_live_ff;

   // configuration and request capture
   always_comb begin
      base_in = base_ff;
      pool_in = pool_ff;
      if (csr_valid) begin
         if (csr_index == bsa_pkg::CSR_BASE_ADDRESS) begin
            base_in = csr_wdata;
         end
         if (csr_index == bsa_pkg::CSR_POOL_SIZE) begin
            pool_in = csr_wdata;
         end
      end
   end

   always_comb begin
      req_kind_in = req_kind_ff;
      bytes_in    = bytes_ff;
      owner_in    = owner_ff;
      rounded_in  = rounded_ff;
      if (cmd.load) begin
         req_kind_in = bsa_pkg::req_kind_type'(req_type);
         bytes_in    = req_request_bytes;
         owner_in    = req_owner_layer;
         rounded_in  = ({1'b0, req_request_bytes} + {1'b0, bsa_pkg::ALIGN_MASK})
                       & ~{1'b0, bsa_pkg::ALIGN_MASK};
      end
   end

   // scan address and registered table read
   assign issue   = cmd.scan && (issue_cnt_ff != CNT_W'(SLOT_COUNT));
   assign rd_addr = issue_cnt_ff[IDX_W-1:0];

   always_comb begin
      issue_cnt_in = issue_cnt_ff;
      if (cmd.load) begin
         issue_cnt_in = '0;
      end else if (issue) begin
         issue_cnt_in = issue_cnt_ff + CNT_W'(1);
      end
      rd_valid_in = issue;
   end

   always_ff @(posedge clock) begin
      rd_offset_ff  <= offset_mem[rd_addr];
      rd_size_ff    <= size_mem[rd_addr];
      rd_owner_ff   <= owner_mem[rd_addr];
      rd_alive_ff   <= alive_ff[rd_addr];
      rd_written_ff <= written_ff[rd_addr];
      rd_idx_ff     <= rd_addr;
      if (geom_we) begin
         offset_mem[wr_idx] <= bump_ff;
         size_mem[wr_idx]   <= rounded_ff[DW-1:0];
      end
      if (owner_we) begin
         owner_mem[wr_idx] <= owner_ff;
      end
   end

   // entries never written read as zero
   assign ent_offset = rd_written_ff ? rd_offset_ff : '0;
   assign ent_size   = rd_written_ff ? rd_size_ff : '0;

   // lowest-index candidates
   always_comb begin
      rel_found_in  = rel_found_ff;
      rel_idx_in    = rel_idx_ff;
      rel_size_in   = rel_size_ff;
      reu_found_in  = reu_found_ff;
      reu_idx_in    = reu_idx_ff;
      reu_size_in   = reu_size_ff;
      reu_offset_in = reu_offset_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.load) begin
         rel_found_in  = 1'b0;
         reu_found_in  = 1'b0;
         free_found_in = 1'b0;
      end else if (rd_valid_ff) begin
         if (!rel_found_ff && rd_alive_ff && (rd_owner_ff == owner_ff)) begin
            rel_found_in = 1'b1;
            rel_idx_in   = rd_idx_ff;
            rel_size_in  = ent_size;
         end
         if (!reu_found_ff && !rd_alive_ff && (ent_size >= bytes_ff)) begin
            reu_found_in  = 1'b1;
            reu_idx_in    = rd_idx_ff;
            reu_size_in   = ent_size;
            reu_offset_in = ent_offset;
         end
         if (!free_found_ff && !rd_alive_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end
   end

   // pool space check
   assign space_sum = {2'b00, bump_ff} + {1'b0, rounded_ff};

   always_comb begin
      space_fail_in = space_fail_ff;
      new_bump_in   = new_bump_ff;
      if (cmd.decide) begin
         space_fail_in = space_sum > {2'b00, pool_ff};
         new_bump_in   = space_sum[DW-1:0];
      end
   end

   // commit
   always_comb begin
      alive_in          = alive_ff;
      written_in        = written_ff;
      bump_in           = bump_ff;
      live_in           = live_ff;
      geom_we           = 1'b0;
      owner_we          = 1'b0;
      wr_idx            = free_idx_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_address_in    = rsp_address_ff;
      rsp_slot_index_in = rsp_slot_index_ff;
      rsp_live_in       = rsp_live_ff;
      if (cmd.commit) begin
         rsp_valid_in      = 1'b1;
         rsp_address_in    = '0;
         rsp_slot_index_in = '0;
         if (req_kind_ff == bsa_pkg::REQ_RELEASE) begin
            if (rel_found_ff) begin
               alive_in[rel_idx_ff] = 1'b0;
               live_in              = live_ff - rel_size_ff;
               rsp_status_in        = bsa_pkg::ST_DONE;
               rsp_slot_index_in    = bsa_pkg::SLOT_INDEX_WIDTH'(rel_idx_ff);
            end else begin
               rsp_status_in = bsa_pkg::ST_NO_OWNER;
            end
         end else begin
            priority if (reu_found_ff) begin
               wr_idx               = reu_idx_ff;
               owner_we             = 1'b1;
               alive_in[reu_idx_ff] = 1'b1;
               live_in              = live_ff + reu_size_ff;
               rsp_status_in        = bsa_pkg::ST_DONE;
               rsp_address_in       = base_ff + reu_offset_ff;
               rsp_slot_index_in    = bsa_pkg::SLOT_INDEX_WIDTH'(reu_idx_ff);
            end else if (space_fail_ff) begin
               rsp_status_in = bsa_pkg::ST_NO_SPACE;
            end else if (free_found_ff) begin
               wr_idx                  = free_idx_ff;
               geom_we                 = 1'b1;
               owner_we                = 1'b1;
               alive_in[free_idx_ff]   = 1'b1;
               written_in[free_idx_ff] = 1'b1;
               bump_in                 = new_bump_ff;
               live_in                 = live_ff + rounded_ff[DW-1:0];
               rsp_status_in           = bsa_pkg::ST_DONE;
               rsp_address_in          = base_ff + bump_ff;
               rsp_slot_index_in       = bsa_pkg::SLOT_INDEX_WIDTH'(free_idx_ff);
            end else begin
               rsp_status_in = bsa_pkg::ST_NO_SLOT;
            end
         end
         rsp_live_in = live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         pool_ff       <= '0;
         issue_cnt_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         rel_found_ff  <= 1'b0;
         reu_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         alive_ff      <= '0;
         written_ff    <= '0;
         bump_ff       <= '0;
         live_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_ff       <= base_in;
         pool_ff       <= pool_in;
         issue_cnt_ff  <= issue_cnt_in;
         rd_valid_ff   <= rd_valid_in;
         rel_found_ff  <= rel_found_in;
         reu_found_ff  <= reu_found_in;
         free_found_ff <= free_found_in;
         alive_ff      <= alive_in;
         written_ff    <= written_in;
         bump_ff       <= bump_in;
         live_ff       <= live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_kind_ff       <= req_kind_in;
      bytes_ff          <= bytes_in;
      owner_ff          <= owner_in;
      rounded_ff        <= rounded_in;
      rel_idx_ff        <= rel_idx_in;
      rel_size_ff       <= rel_size_in;
      reu_idx_ff        <= reu_idx_in;
      reu_size_ff       <= reu_size_in;
      reu_offset_ff     <= reu_offset_in;
      free_idx_ff       <= free_idx_in;
      space_fail_ff     <= space_fail_in;
      new_bump_ff       <= new_bump_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_address_ff    <= rsp_address_in;
      rsp_slot_index_ff <= rsp_slot_index_in;
      rsp_live_ff       <= rsp_live_in;
   end

endmodule

[sv/bump_slot_allocator.sv]
// A request (allocate or release) is taken only when the block is idle and
// gives exactly one result, after a scan that reads the slot table one
// entry per cycle through its registered memory read port. The result
// waits in an output register, so a new request is taken while the
// previous result is still unclaimed; the commit of the next result waits
// until that register is free. Allocate reuses the lowest free slot large
// enough, otherwise takes the lowest free slot at the bump offset with the
// size rounded up to a multiple of 64 bytes, provided it fits in
// pool_size. Configuration writes are always accepted and should be made
// only while the block is idle; they do not clear the slot table.
// ----------------------------------------------------------------------------
// bump_slot_allocator
// Top level: controller and datapath of the bump allocator with slot reuse.
// ----------------------------------------------------------------------------
module bump_slot_allocator #(
   parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [bsa_pkg::DATA_WIDTH-1:0]         req_request_bytes,
   input  logic [bsa_pkg::OWNER_WIDTH-1:0]        req_owner_layer,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [bsa_pkg::DATA_WIDTH-1:0]         rsp_address,
   output logic [bsa_pkg::SLOT_INDEX_WIDTH-1:0]   rsp_slot_index,
   output logic [bsa_pkg::DATA_WIDTH-1:0]         rsp_live_bytes,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bsa_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bsa_pkg::DATA_WIDTH-1:0]         csr_wdata
);

   bsa_pkg::ctrl_cmd_type  cmd;
   bsa_pkg::dp_status_type status;

   bsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsa_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_request_bytes (req_request_bytes),
      .req_owner_layer   (req_owner_layer),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_live_bytes    (rsp_live_bytes)
   );

endmodule

[sv/bsa_checker.sv]
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks of the bump slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [1:0]                             rsp_status,
   input logic [bsa_pkg::DATA_WIDTH-1:0]         rsp_address,
   input logic [bsa_pkg::SLOT_INDEX_WIDTH-1:0]   rsp_slot_index,
   input logic [bsa_pkg::DATA_WIDTH-1:0]         rsp_live_bytes
);

   logic [bsa_pkg::DATA_WIDTH-1:0] last_live_ff, last_live_in;

   // live total as of the last result transfer
   always_comb begin
      last_live_in = last_live_ff;
      if (rsp_valid && rsp_ready) begin
         last_live_in = rsp_live_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_live_ff <= '0;
      end else begin
         last_live_ff <= last_live_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address)
         && $stable(rsp_status) && $stable(rsp_live_bytes))
      else $error("result changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bsa_pkg::ST_DONE)
         |-> (rsp_address == '0) && (rsp_slot_index == '0))
      else $error("failed result carries address or slot");

   a_fail_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bsa_pkg::ST_DONE) |-> rsp_live_bytes == last_live_ff)
      else $error("failed request changed live bytes");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during scan");

endmodule

bind bump_slot_allocator bsa_checker u_bsa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_address    (rsp_address),
   .rsp_slot_index (rsp_slot_index),
   .rsp_live_bytes (rsp_live_bytes)
);

[tb/bump_slot_allocator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bump_slot_allocator_test
// Self-checking bench for the bump slot allocator. A slot table model in the
// bench predicts status, address, slot and live bytes of every request and
// the results are compared in order. Directed cases cover fresh slots,
// oversized requests, address wrap, the exact pool boundary and a full slot
// table; random phases with varying base and pool settings follow, with
// random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module bump_slot_allocator_test;

   localparam int SLOT_COUNT  = bsa_pkg::SLOT_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;

   localparam logic [bsa_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [bsa_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      bsa_pkg::status_type status;
      logic [31:0]         address;
      logic [5:0]          slot_index;
      logic [31:0]         live_bytes;
   } alloc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = bsa_pkg::REQ_ALLOC;
   logic [31:0] req_request_bytes = '0;
   logic [15:0] req_owner_layer = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_address;
   logic [5:0]  rsp_slot_index;
   logic [31:0] rsp_live_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   logic [31:0] model_offset [SLOT_COUNT] = '{default: '0};
   logic [31:0] model_size   [SLOT_COUNT] = '{default: '0};
   logic [15:0] model_owner  [SLOT_COUNT] = '{default: '0};
   logic        model_alive  [SLOT_COUNT] = '{default: 1'b0};
   logic [31:0] model_bump = '0;
   logic [31:0] model_live = '0;
   logic [31:0] model_base = '0;
   logic [31:0] model_pool = '0;

   alloc_result_type predicted_results [$];

   int          mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_enabled = 1'b1;
   int          hold_request = 0;
   int          hold_left = 0;

   bump_slot_allocator #(.SLOT_COUNT(SLOT_COUNT)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_request_bytes (req_request_bytes),
      .req_owner_layer   (req_owner_layer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_live_bytes    (rsp_live_bytes),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic alloc_result_type predict_allocator(bsa_pkg::req_kind_type kind,
                                                          logic [31:0] bytes,
                                                          logic [15:0] owner);
      alloc_result_type r;
      logic [32:0]      rounded;
      logic [33:0]      reach;
      int               hit;
      int               i;
      r.status = bsa_pkg::ST_DONE;
      r.address = '0;
      r.slot_index = '0;
      hit = -1;
      if (kind == bsa_pkg::REQ_RELEASE) begin
         for (i = 0; i < SLOT_COUNT; i++)
            if (hit < 0 && model_alive[i] && model_owner[i] == owner) hit = i;
         if (hit >= 0) begin
            model_alive[hit] = 1'b0;
            model_live = model_live - model_size[hit];
            r.slot_index = hit[5:0];
         end else begin
            r.status = bsa_pkg::ST_NO_OWNER;
         end
      end else begin
         for (i = 0; i < SLOT_COUNT; i++)
            if (hit < 0 && !model_alive[i] && model_size[i] >= bytes) hit = i;
         if (hit >= 0) begin
            model_alive[hit] = 1'b1;
            model_owner[hit] = owner;
            model_live = model_live + model_size[hit];
            r.address = model_base + model_offset[hit];
            r.slot_index = hit[5:0];
         end else begin
            rounded = ({1'b0, bytes} + {1'b0, bsa_pkg::ALIGN_MASK})
                      & ~{1'b0, bsa_pkg::ALIGN_MASK};
            reach = {2'b00, model_bump} + {1'b0, rounded};
            if (reach > {2'b00, model_pool}) begin
               r.status = bsa_pkg::ST_NO_SPACE;
            end else begin
               for (i = 0; i < SLOT_COUNT; i++)
                  if (hit < 0 && !model_alive[i]) hit = i;
               if (hit >= 0) begin
                  model_offset[hit] = model_bump;
                  model_size[hit] = rounded[31:0];
                  model_owner[hit] = owner;
                  model_alive[hit] = 1'b1;
                  model_live = model_live + rounded[31:0];
                  r.address = model_base + model_bump;
                  r.slot_index = hit[5:0];
                  model_bump = model_bump + rounded[31:0];
               end else begin
                  r.status = bsa_pkg::ST_NO_SLOT;
               end
            end
         end
      end
      r.live_bytes = model_live;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result transfer with nothing expected: status %0d", rsp_status);
            end else begin
               want = predicted_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("address", want.address, rsp_address);
               check_field("slot_index", 32'(want.slot_index), 32'(rsp_slot_index));
               check_field("live_bytes", want.live_bytes, rsp_live_bytes);
            end
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_enabled && $urandom_range(99) < 13);
         end
      end
   end

   task automatic send_request(bsa_pkg::req_kind_type kind, logic [31:0] bytes,
                               logic [15:0] owner);
      while (idle_enabled && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_request_bytes <= bytes;
      req_owner_layer <= owner;
      do @(posedge clock); while (!req_ready);
      predicted_results.push_back(predict_allocator(kind, bytes, owner));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         bsa_pkg::CSR_BASE_ADDRESS: model_base = data;
         bsa_pkg::CSR_POOL_SIZE:    model_pool = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] base, logic [31:0] pool);
      wait_idle();
      csr_write(bsa_pkg::CSR_BASE_ADDRESS, base);
      csr_write(bsa_pkg::CSR_POOL_SIZE, pool);
   endtask

   task automatic send_random_item(int alloc_pct);
      bsa_pkg::req_kind_type kind;
      logic [31:0]           bytes;
      logic [15:0]           owner;
      int                    pick;
      kind = ($urandom_range(99) < alloc_pct) ? bsa_pkg::REQ_ALLOC : bsa_pkg::REQ_RELEASE;
      pick = $urandom_range(99);
      if (pick < 55) bytes = $urandom_range(256);
      else if (pick < 75) bytes = $urandom_range(4096);
      else if (pick < 85) bytes = '0;
      else if (pick < 92) bytes = $urandom_range(65536);
      else if (pick < 96) bytes = $urandom;
      else bytes = 32'hFFFF_FFFF - $urandom_range(127);
      pick = $urandom_range(99);
      if (pick < 85) owner = 16'($urandom_range(7));
      else if (pick < 95) owner = 16'($urandom_range(63));
      else owner = 16'($urandom);
      if ($urandom_range(99) < 5) begin
         kind = bsa_pkg::req_kind_type'($urandom_range(1));
         bytes = $urandom;
         owner = 16'($urandom);
      end
      send_request(kind, bytes, owner);
   endtask

   task automatic test_fresh_slots();
      configure(32'h0, 32'h0);
      csr_write(CSR_SPARE_LO, 32'hFFFF_FFFF);
      csr_write(CSR_SPARE_HI, 32'hA5A5_5A5A);
      send_request(bsa_pkg::REQ_ALLOC, 32'd0, 16'd0);
      send_request(bsa_pkg::REQ_ALLOC, 32'd1, 16'd1);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'hFFFF);
      send_request(bsa_pkg::REQ_RELEASE, 32'hFFFF_FFFF, 16'd0);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'd0);
   endtask

   task automatic test_oversize_and_wrap();
      configure(32'hFFFF_FFC0, 32'hFFFF_FFFF);
      send_request(bsa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 16'd1);
      send_request(bsa_pkg::REQ_ALLOC, 32'hFFFF_FFC1, 16'd1);
      send_request(bsa_pkg::REQ_ALLOC, 32'd100, 16'd1);
      send_request(bsa_pkg::REQ_ALLOC, 32'd64, 16'd2);
      send_request(bsa_pkg::REQ_ALLOC, 32'd0, 16'd3);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'd1);
      send_request(bsa_pkg::REQ_ALLOC, 32'd50, 16'd4);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'd2);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'd3);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'd4);
   endtask

   task automatic test_pool_boundary();
      wait_idle();
      configure($urandom, model_bump + 32'd192);
      send_request(bsa_pkg::REQ_ALLOC, 32'd129, 16'd5);
      send_request(bsa_pkg::REQ_ALLOC, 32'd1, 16'd6);
      send_request(bsa_pkg::REQ_ALLOC, 32'd65, 16'd7);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'd5);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'd6);
      send_request(bsa_pkg::REQ_RELEASE, 32'd0, 16'd7);
   endtask

   task automatic test_slot_exhaustion();
      int i;
      configure($urandom, 32'hFFFF_FFFF);
      for (i = 0; i < SLOT_COUNT + 2; i++)
         send_request(bsa_pkg::REQ_ALLOC, $urandom_range(200), 16'h0100 + 16'(i));
      send_request(bsa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 16'h0200);
      send_request(bsa_pkg::REQ_ALLOC, 32'd0, 16'h0200);
      for (i = 0; i < SLOT_COUNT + 2; i++)
         send_request(bsa_pkg::REQ_RELEASE, $urandom, 16'h0100 + 16'(i));
   endtask

   task automatic test_backpressure();
      int i;
      configure($urandom, 32'hFFFF_FFFF);
      hold_request = 600;
      for (i = 0; i < 40; i++)
         send_random_item(60);
   endtask

   task automatic test_random_traffic();
      logic [31:0] base;
      logic [31:0] pool;
      logic [31:0] span;
      int          phase;
      int          i;
      for (phase = 0; phase < 10; phase++) begin
         wait_idle();
         span = $urandom_range(16384);
         case (phase % 5)
            0: pool = (model_bump > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : model_bump + span;
            1: pool = (model_bump > span) ? model_bump - span : 32'h0;
            2: pool = $urandom;
            3: pool = 32'h0;
            default: pool = 32'hFFFF_FFFF;
         endcase
         case (phase % 3)
            0: base = 32'h0;
            1: base = 32'hFFFF_FFFF;
            default: base = $urandom;
         endcase
         configure(base, pool);
         idle_enabled = (phase != 6);
         for (i = 0; i < 130; i++)
            send_random_item(35 + (phase * 13) % 50);
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fresh_slots();
      test_oversize_and_wrap();
      test_pool_boundary();
      test_slot_exhaustion();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (SLOT_COUNT + 8) @(posedge clock);
      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
